// File: rtl/geometry_intersection_predicates_assert.svh
// Assertion macros shared by the checker. The including module must have
// signals named clk and rst_n.
`ifndef GEOMETRY_INTERSECTION_PREDICATES_ASSERT_SVH
`define GEOMETRY_INTERSECTION_PREDICATES_ASSERT_SVH

// Check cons in the same cycle as ante, outside reset.
`define GIP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("geometry predicate check failed");

// Check cons in the cycle after ante, outside reset.
`define GIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("geometry predicate check failed");

`endif

// File: rtl/gip_pkg.sv
package gip_pkg;

  // Coordinate word width, fixed by the beat layout
  localparam int COORD_BITS = 16;
  // Lane operand width: holds a coordinate difference or a negated coordinate
  localparam int OP_BITS    = COORD_BITS + 2;
  localparam int PROD_BITS  = 2 * OP_BITS;
  localparam int SUM_BITS   = PROD_BITS + 2;
  localparam int NUM_LANES  = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OP_BITS-1:0]    operand_t;
  typedef logic [2:0]                   mode_t;
  typedef logic [1:0]                   sign_t;

  // Predicate selector
  localparam mode_t MODE_ORIENT    = 3'd0;
  localparam mode_t MODE_ON_SEG    = 3'd1;
  localparam mode_t MODE_SEG_SEG   = 3'd2;
  localparam mode_t MODE_LINE_LINE = 3'd3;
  localparam mode_t MODE_RAY_LINE  = 3'd4;
  localparam mode_t MODE_RAY_RAY   = 3'd5;
  localparam mode_t MODE_HALFPLANE = 3'd6;

  // Sign codes; they double as the turn codes of the orientation result
  localparam sign_t SGN_ZERO = 2'd0;
  localparam sign_t SGN_POS  = 2'd1;
  localparam sign_t SGN_NEG  = 2'd2;

  typedef struct packed {
    mode_t  mode;
    coord_t a_x;
    coord_t a_y;
    coord_t b_x;
    coord_t b_y;
    coord_t c_x;
    coord_t c_y;
    coord_t d_x;
    coord_t d_y;
  } in_item_t;

  typedef struct packed {
    logic  hit;
    sign_t turn;
  } out_item_t;

  // One lane computes sign(x1*y1 - x2*y2 + k)
  typedef struct packed {
    operand_t x1;
    operand_t y1;
    operand_t x2;
    operand_t y2;
    operand_t k;
  } lane_ops_t;

  typedef lane_ops_t [NUM_LANES-1:0] lane_ops_arr_t;
  typedef sign_t [NUM_LANES-1:0]     lane_sign_arr_t;

endpackage

// File: rtl/gip_operand_sel.sv
module gip_operand_sel (
  input  gip_pkg::in_item_t      item,
  output gip_pkg::lane_ops_arr_t ops
);
  import gip_pkg::*;

  operand_t ax, ay, bx, by, cx, cy, dx, dy, ex, ey;

  function automatic lane_ops_t mk(operand_t x1, operand_t y1, operand_t x2,
                                   operand_t y2, operand_t k);
    lane_ops_t r;
    r.x1 = x1;
    r.y1 = y1;
    r.x2 = x2;
    r.y2 = y2;
    r.k  = k;
    return r;
  endfunction

  // Widen the coordinates
  assign ax = OP_BITS'(item.a_x);
  assign ay = OP_BITS'(item.a_y);
  assign bx = OP_BITS'(item.b_x);
  assign by = OP_BITS'(item.b_y);
  assign cx = OP_BITS'(item.c_x);
  assign cy = OP_BITS'(item.c_y);
  assign dx = OP_BITS'(item.d_x);
  assign dy = OP_BITS'(item.d_y);
  // Offset of ray B origin from ray A origin
  assign ex = cx - ax;
  assign ey = cy - ay;

  // Route operands to the four lanes per predicate
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      ops[i] = '0;
    end
    case (item.mode)
      MODE_ORIENT, MODE_ON_SEG, MODE_SEG_SEG: begin
        // Cross products ABxAC, ABxAD, CDxCA, CDxCB
        ops[0] = mk(bx - ax, cy - ay, by - ay, cx - ax, '0);
        ops[1] = mk(bx - ax, dy - ay, by - ay, dx - ax, '0);
        ops[2] = mk(dx - cx, ay - cy, dy - cy, ax - cx, '0);
        ops[3] = mk(dx - cx, by - cy, dy - cy, bx - cx, '0);
      end
      MODE_LINE_LINE: begin
        // Determinant, then the two parallel-coincidence tests
        ops[0] = mk(ax, cy, cx, ay, '0);
        ops[1] = mk(dx, ay, bx, cy, '0);
        ops[2] = mk(dx, ax, bx, cx, '0);
      end
      MODE_RAY_LINE: begin
        // Direction dot normal, and line value at the ray origin
        ops[0] = mk(bx, cx, -by, cy, '0);
        ops[1] = mk(cx, ax, -cy, ay, dx);
      end
      MODE_RAY_RAY: begin
        // Determinant, both parameter numerators, direction dot product
        ops[0] = mk(dx, by, dy, bx, '0);
        ops[1] = mk(ex, dy, ey, dx, '0);
        ops[2] = mk(ex, by, ey, bx, '0);
        ops[3] = mk(bx, dx, -by, dy, '0);
      end
      MODE_HALFPLANE: begin
        ops[0] = mk(ax, cx, -ay, cy, bx);
      end
      default: begin
        ops[0] = '0;
      end
    endcase
  end

endmodule

// File: rtl/gip_lane.sv
module gip_lane (
  input  gip_pkg::lane_ops_t ops,
  output gip_pkg::sign_t     sgn
);
  import gip_pkg::*;

  logic signed [PROD_BITS-1:0] p1;
  logic signed [PROD_BITS-1:0] p2;
  logic signed [SUM_BITS-1:0]  sum;

  // Two products, their difference plus the constant term
  assign p1  = ops.x1 * ops.y1;
  assign p2  = ops.x2 * ops.y2;
  assign sum = SUM_BITS'(p1) - SUM_BITS'(p2) + SUM_BITS'(ops.k);

  // Reduce to a sign code
  always_comb begin
    if (sum[SUM_BITS-1]) begin
      sgn = SGN_NEG;
    end else if (sum != '0) begin
      sgn = SGN_POS;
    end else begin
      sgn = SGN_ZERO;
    end
  end

endmodule

// File: rtl/gip_decide.sv
module gip_decide (
  input  gip_pkg::in_item_t       item,
  input  gip_pkg::lane_sign_arr_t sgn,
  output gip_pkg::out_item_t      res
);
  import gip_pkg::*;

  logic box_c_ab, box_d_ab, box_a_cd, box_b_cd;
  logic hit;
  sign_t turn;

  // Closed range test against two unordered ends
  function automatic logic between(coord_t v, coord_t e1, coord_t e2);
    logic fwd, rev;
    fwd = (v >= e1) && (v <= e2);
    rev = (v >= e2) && (v <= e1);
    return fwd || rev;
  endfunction

  // Bounding box tests of a point against a segment
  assign box_c_ab = between(item.c_x, item.a_x, item.b_x) &&
                    between(item.c_y, item.a_y, item.b_y);
  assign box_d_ab = between(item.d_x, item.a_x, item.b_x) &&
                    between(item.d_y, item.a_y, item.b_y);
  assign box_a_cd = between(item.a_x, item.c_x, item.d_x) &&
                    between(item.a_y, item.c_y, item.d_y);
  assign box_b_cd = between(item.b_x, item.c_x, item.d_x) &&
                    between(item.b_y, item.c_y, item.d_y);

  // Combine lane signs per predicate
  always_comb begin
    hit  = 1'b0;
    turn = SGN_ZERO;
    case (item.mode)
      MODE_ORIENT: begin
        turn = sgn[0];
      end
      MODE_ON_SEG: begin
        hit = (sgn[0] == SGN_ZERO) && box_c_ab;
      end
      MODE_SEG_SEG: begin
        hit = ((sgn[0] != sgn[1]) && (sgn[2] != sgn[3])) ||
              ((sgn[0] == SGN_ZERO) && box_c_ab) ||
              ((sgn[1] == SGN_ZERO) && box_d_ab) ||
              ((sgn[2] == SGN_ZERO) && box_a_cd) ||
              ((sgn[3] == SGN_ZERO) && box_b_cd);
      end
      MODE_LINE_LINE: begin
        if (sgn[0] != SGN_ZERO) begin
          hit = 1'b1;
        end else if (item.a_y != '0) begin
          hit = (sgn[1] == SGN_ZERO);
        end else begin
          hit = (sgn[2] == SGN_ZERO);
        end
      end
      MODE_RAY_LINE: begin
        // Parallel: origin must lie on the line; else parameter must be >= 0
        if (sgn[0] == SGN_ZERO) begin
          hit = (sgn[1] == SGN_ZERO);
        end else begin
          hit = (sgn[1] == SGN_ZERO) || (sgn[1] != sgn[0]);
        end
      end
      MODE_RAY_RAY: begin
        if (sgn[0] == SGN_ZERO) begin
          hit = (sgn[2] == SGN_ZERO) && (sgn[3] == SGN_POS);
        end else begin
          hit = ((sgn[1] == SGN_ZERO) || (sgn[1] == sgn[0])) &&
                ((sgn[2] == SGN_ZERO) || (sgn[2] == sgn[0]));
        end
      end
      MODE_HALFPLANE: begin
        hit = (sgn[0] != SGN_NEG);
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign res.hit  = hit;
  assign res.turn = turn;

endmodule

// File: rtl/geometry_intersection_predicates.sv
// 2D exact integer predicate unit. Each input beat carries a mode and eight
// signed coordinate words; each produces exactly one result beat with hit and
// turn. One beat is accepted per clock when the output does not stall; each beat
// moves from input acceptance to result valid through the input register and
// the result register, with four shared product-difference lanes in between.
// Under output backpressure both registers hold and the input stalls once full.
module geometry_intersection_predicates (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gip_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gip_pkg::out_item_t  out_data
);
  import gip_pkg::*;

  logic           in_valid_r, in_valid_nxt;
  in_item_t       in_data_r;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_data_r;
  logic           advance;
  lane_ops_arr_t  lane_ops;
  lane_sign_arr_t lane_sign;
  out_item_t      result;

  // Pipeline flow: the result register moves when empty or drained
  assign advance      = !out_valid_r || out_ready;
  assign in_ready     = !in_valid_r || advance;
  assign in_valid_nxt = in_ready ? in_valid : in_valid_r;
  assign out_valid_nxt = advance ? in_valid_r : out_valid_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Predicate datapath
  gip_operand_sel u_sel (
    .item (in_data_r),
    .ops  (lane_ops)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    gip_lane u_lane (
      .ops (lane_ops[g]),
      .sgn (lane_sign[g])
    );
  end

  gip_decide u_decide (
    .item (in_data_r),
    .sgn  (lane_sign),
    .res  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/gip_checker.sv
module gip_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input gip_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input gip_pkg::out_item_t out_data
);
  import gip_pkg::*;

`include "geometry_intersection_predicates_assert.svh"

  logic in_beat;

  assign in_beat = in_valid && in_ready;

  // Hold a stalled input beat
  `GIP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))

  // Hold a stalled result beat
  `GIP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // A result never reports a hit together with a turn
  `GIP_ASSERT_SAME(a_hit_turn_excl, out_valid, !(out_data.hit && (out_data.turn != SGN_ZERO)))

  // A new result appears only after an accepted beat has passed the input and result registers
  `GIP_ASSERT_SAME(a_latency, $rose(out_valid), $past(in_beat, 2))

  // An empty result register never blocks the input
  `GIP_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind geometry_intersection_predicates gip_checker u_gip_checker (.*);
